@@ design/mahd_pkg.sv @@
// package for the mpeg audio header decoder: status and samplerate codes,
// rate tables, reciprocal constants and crc constants; no dependencies
`default_nettype none

package mahd_pkg;

  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StNoSync     = 3'd1,
    StLostSync   = 3'd2,
    StBadLayer   = 3'd3,
    StBadBitrate = 3'd4,
    StBadRate    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    Fs44k1 = 2'd0,
    Fs48k  = 2'd1,
    Fs32k  = 2'd2
  } fs_e;

  // constant divider: q = floor(x / d), with d = 441, 48 or 32 for 44.1, 48 and 32 kHz
  localparam int unsigned DivXW    = 26;
  localparam int unsigned RecipW   = 22;
  localparam int unsigned DivQW    = DivXW + RecipW - DivXW;
  localparam int unsigned DivShift = DivXW;
  localparam int unsigned DivDW    = 9;

  localparam logic [RecipW-1:0] Recip44k1 = 22'd152174;
  localparam logic [RecipW-1:0] Recip48k  = 22'd1398101;
  localparam logic [RecipW-1:0] Recip32k  = 22'd2097152;
  localparam logic [DivDW-1:0]  Div44k1   = 9'd441;
  localparam logic [DivDW-1:0]  Div48k    = 9'd48;
  localparam logic [DivDW-1:0]  Div32k    = 9'd32;

  localparam logic [15:0] CrcPoly = 16'h8005;
  localparam logic [15:0] CrcInit = 16'hffff;

  localparam logic [10:0] Pcm384  = 11'd384;
  localparam logic [10:0] Pcm576  = 11'd576;
  localparam logic [10:0] Pcm1152 = 11'd1152;

  localparam logic [8:0] RateTab [5][15] = '{
    '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd288,
      9'd320, 9'd352, 9'd384, 9'd416, 9'd448},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd160,
      9'd192, 9'd224, 9'd256, 9'd320, 9'd384},
    '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128,
      9'd160, 9'd192, 9'd224, 9'd256, 9'd320},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144,
      9'd160, 9'd176, 9'd192, 9'd224, 9'd256},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80,
      9'd96, 9'd112, 9'd128, 9'd144, 9'd160}
  };

  function automatic logic [8:0] rate_kbps(input logic [2:0] row, input logic [3:0] idx);
    logic [8:0] r;
    r = '0;
    if (row < 3'd5 && idx != 4'd15) begin
      r = RateTab[row][idx];
    end
    return r;
  endfunction

  function automatic logic [15:0] base_hz(input fs_e fs);
    logic [15:0] r;
    unique case (fs)
      Fs44k1:  r = 16'd44100;
      Fs48k:   r = 16'd48000;
      Fs32k:   r = 16'd32000;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/mpeg_audio_header_decoder.sv @@
// top level of the mpeg audio frame header decoder: seven-stage pipeline
// depends on mahd_pkg and mahd_cdiv
//
// usage
//   input channel: in_valid_i / in_ready_o with one 32-bit header word per request
//   output channel: out_valid_o / out_ready_i with the decoded fields as separate ports
//   every stage holds its own valid bit; a stage loads when it is empty or when
//   the stage after it moves, so bubbles close up and nothing is dropped or repeated
//   throughput: one header per cycle while out_ready_i is high, through the seven register stages
//   (input, decode, scaling, three divider stages, output register)
//   frame length and duration come from the two three-stage reciprocal dividers
//   while out_ready_i is low the pipeline keeps filling; in_ready_o drops only
//   once all seven stages hold a request
//   reset clears every valid bit; the datapath registers are not reset
`default_nettype none

module mpeg_audio_header_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] header_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [2:0]  layer_o,
  output logic [18:0] bitrate_bps_o,
  output logic [15:0] samplerate_hz_o,
  output logic [11:0] frame_bytes_o,
  output logic [1:0]  channels_o,
  output logic [10:0] pcm_samples_o,
  output logic [17:0] frame_time_us_o,
  output logic        padding_o,
  output logic        free_format_o,
  output logic        crc_follows_o,
  output logic [15:0] header_crc_o
);

  localparam int unsigned NStages = 7;

  typedef struct packed {
    mahd_pkg::status_e status;
    logic [2:0]        layer;
    logic [8:0]        kbps;
    logic [10:0]       kmul;
    logic [13:0]       dmul;
    mahd_pkg::fs_e     fs;
    logic [1:0]        shift;
    logic [10:0]       pcm;
    logic [1:0]        chans;
    logic              pad;
    logic              prot;
    logic              freef;
    logic              l1;
    logic [15:0]       crc;
    logic [7:0]        lo;
  } dec_t;

  typedef struct packed {
    mahd_pkg::status_e status;
    logic [2:0]        layer;
    logic [18:0]       br;
    logic [15:0]       sr;
    logic [1:0]        chans;
    logic [10:0]       pcm;
    logic              pad;
    logic              prot;
    logic              freef;
    logic              l1;
    logic [15:0]       crc;
  } info_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = crc_in;
    for (int i = 7; i >= 0; i--) begin
      fb = data[i] ^ c[15];
      c  = {c[14:0], 1'b0} ^ (fb ? mahd_pkg::CrcPoly : 16'h0000);
    end
    return c;
  endfunction

  logic [NStages-1:0] vld_q, vld_d;
  logic [NStages:0]   en;

  logic [31:0]                 hdr_q;
  dec_t                        dec_d, dec_q;
  info_t                       info_d;
  info_t                       info_q [4];
  logic [mahd_pkg::DivXW-1:0]  xf_d, xd_d, xf_q, xd_q;
  mahd_pkg::fs_e               fs_q;
  logic [mahd_pkg::DivQW-1:0]  qf, qd;

  logic [2:0]  st_q, lay_q;
  logic [18:0] br_q;
  logic [15:0] sr_q, crc_q;
  logic [11:0] fb_q, fb_d, fb_sum;
  logic [1:0]  ch_q;
  logic [10:0] pcm_q;
  logic [17:0] dur_q, dur_d;
  logic        pad_q, free_q, prot_q;

  // request handshake along the stages
  always_comb begin
    en[NStages] = out_ready_i;
    for (int k = NStages - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign vld_d = {vld_q[NStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (vld_d & en[NStages-1:0]) | (vld_q & ~en[NStages-1:0]);
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NStages-1];

  // decode
  always_comb begin
    logic        lsf, v25;
    logic [2:0]  layer, row;
    logic [3:0]  bidx;
    logic [7:0]  k;
    lsf   = !hdr_q[19];
    v25   = !hdr_q[20];
    layer = 3'd4 - {1'b0, hdr_q[18:17]};
    bidx  = hdr_q[15:12];
    row   = lsf ? (3'd3 + {2'b00, layer[1]}) : (layer - 3'd1);

    priority if (hdr_q[31:21] != 11'h7ff) begin
      dec_d.status = mahd_pkg::StNoSync;
    end else if (!lsf && v25) begin
      dec_d.status = mahd_pkg::StLostSync;
    end else if (layer == 3'd4) begin
      dec_d.status = mahd_pkg::StBadLayer;
    end else if (bidx == 4'd15) begin
      dec_d.status = mahd_pkg::StBadBitrate;
    end else if (hdr_q[11:10] == 2'd3) begin
      dec_d.status = mahd_pkg::StBadRate;
    end else begin
      dec_d.status = mahd_pkg::StOk;
    end

    if (layer == 3'd1) begin
      k           = 8'd12;
      dec_d.pcm   = mahd_pkg::Pcm384;
    end else if (layer == 3'd3 && lsf) begin
      k           = 8'd72;
      dec_d.pcm   = mahd_pkg::Pcm576;
    end else begin
      k           = 8'd144;
      dec_d.pcm   = mahd_pkg::Pcm1152;
    end

    dec_d.fs    = mahd_pkg::fs_e'(hdr_q[11:10]);
    dec_d.layer = layer;
    dec_d.kbps  = mahd_pkg::rate_kbps(row, bidx);
    dec_d.kmul  = (dec_d.fs == mahd_pkg::Fs44k1) ? (11'(k) * 11'd10) : 11'(k);
    dec_d.dmul  = (dec_d.fs == mahd_pkg::Fs44k1) ? 14'd10000 : 14'd1000;
    dec_d.shift = lsf ? (v25 ? 2'd2 : 2'd1) : 2'd0;
    dec_d.chans = (hdr_q[7:6] == 2'd3) ? 2'd1 : 2'd2;
    dec_d.pad   = hdr_q[9];
    dec_d.prot  = !hdr_q[16];
    dec_d.freef = (bidx == 4'd0);
    dec_d.l1    = (layer == 3'd1);
    dec_d.crc   = crc_byte(mahd_pkg::CrcInit, hdr_q[15:8]);
    dec_d.lo    = hdr_q[7:0];
  end

  // scaling for the dividers
  always_comb begin
    logic [19:0] nf;
    logic [24:0] nd;
    nf   = dec_q.kbps * dec_q.kmul;
    nd   = dec_q.pcm * dec_q.dmul;
    xf_d = mahd_pkg::DivXW'(nf) << dec_q.shift;
    xd_d = mahd_pkg::DivXW'(nd) << dec_q.shift;

    info_d.status = dec_q.status;
    info_d.layer  = dec_q.layer;
    info_d.br     = 19'(dec_q.kbps * 10'd1000);
    info_d.sr     = mahd_pkg::base_hz(dec_q.fs) >> dec_q.shift;
    info_d.chans  = dec_q.chans;
    info_d.pcm    = dec_q.pcm;
    info_d.pad    = dec_q.pad;
    info_d.prot   = dec_q.prot;
    info_d.freef  = dec_q.freef;
    info_d.l1     = dec_q.l1;
    info_d.crc    = crc_byte(dec_q.crc, dec_q.lo);

    if (dec_q.status == mahd_pkg::StNoSync) begin
      info_d        = '0;
      info_d.status = mahd_pkg::StNoSync;
    end else if (dec_q.status != mahd_pkg::StOk) begin
      info_d.br    = '0;
      info_d.sr    = '0;
      info_d.freef = 1'b0;
    end
  end

  mahd_cdiv u_div_frame (
    .clk_i (clk_i),
    .en_i  (en[5:3]),
    .fs_i  (fs_q),
    .x_i   (xf_q),
    .q_o   (qf)
  );

  mahd_cdiv u_div_dur (
    .clk_i (clk_i),
    .en_i  (en[5:3]),
    .fs_i  (fs_q),
    .x_i   (xd_q),
    .q_o   (qd)
  );

  // output formatting
  assign fb_sum = 12'(qf) + {11'b0, info_q[3].pad};

  always_comb begin
    if (info_q[3].status != mahd_pkg::StOk || info_q[3].freef) begin
      fb_d = '0;
    end else if (info_q[3].l1) begin
      fb_d = {fb_sum[9:0], 2'b00};
    end else begin
      fb_d = fb_sum;
    end
    dur_d = (info_q[3].status == mahd_pkg::StOk) ? 18'(qd) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      hdr_q <= header_word_i;
    end
    if (en[1]) begin
      dec_q <= dec_d;
    end
    if (en[2]) begin
      info_q[0] <= info_d;
      xf_q      <= xf_d;
      xd_q      <= xd_d;
      fs_q      <= dec_q.fs;
    end
    if (en[3]) begin
      info_q[1] <= info_q[0];
    end
    if (en[4]) begin
      info_q[2] <= info_q[1];
    end
    if (en[5]) begin
      info_q[3] <= info_q[2];
    end
    if (en[6]) begin
      st_q   <= info_q[3].status;
      lay_q  <= info_q[3].layer;
      br_q   <= info_q[3].br;
      sr_q   <= info_q[3].sr;
      fb_q   <= fb_d;
      ch_q   <= info_q[3].chans;
      pcm_q  <= info_q[3].pcm;
      dur_q  <= dur_d;
      pad_q  <= info_q[3].pad;
      free_q <= info_q[3].freef;
      prot_q <= info_q[3].prot;
      crc_q  <= info_q[3].crc;
    end
  end

  assign status_o        = st_q;
  assign layer_o         = lay_q;
  assign bitrate_bps_o   = br_q;
  assign samplerate_hz_o = sr_q;
  assign frame_bytes_o   = fb_q;
  assign channels_o      = ch_q;
  assign pcm_samples_o   = pcm_q;
  assign frame_time_us_o = dur_q;
  assign padding_o       = pad_q;
  assign free_format_o   = free_q;
  assign crc_follows_o   = prot_q;
  assign header_crc_o    = crc_q;

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&vld_q) && !out_ready_i)
    else $error("input stalled while the pipeline has room");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != mahd_pkg::StOk) |->
      frame_bytes_o == '0 && frame_time_us_o == '0)
    else $error("rejected header carries a frame length or duration");

  a_free_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && free_format_o |-> status_o == mahd_pkg::StOk && frame_bytes_o == '0)
    else $error("free format result inconsistent");

endmodule

`default_nettype wire

@@ design/mahd_cdiv.sv @@
// three-stage divider by one of the three base sample rates (scaled)
// reciprocal multiply, back-multiply, single correction step; uses mahd_pkg
`default_nettype none

module mahd_cdiv (
  input  logic                         clk_i,
  input  logic [2:0]                   en_i,
  input  mahd_pkg::fs_e                fs_i,
  input  logic [mahd_pkg::DivXW-1:0]   x_i,
  output logic [mahd_pkg::DivQW-1:0]   q_o
);

  localparam int unsigned PW  = mahd_pkg::DivXW + mahd_pkg::RecipW;
  localparam int unsigned P2W = mahd_pkg::DivQW + mahd_pkg::DivDW;

  logic [mahd_pkg::RecipW-1:0] recip;
  logic [mahd_pkg::DivDW-1:0]  dsr;
  logic [PW-1:0]               prod_d, prod_q;
  logic [mahd_pkg::DivXW-1:0]  xa_q, xb_q;
  logic [mahd_pkg::DivDW-1:0]  da_q, db_q;
  logic [mahd_pkg::DivQW-1:0]  qest, qb_q, q_d, q_q;
  logic [P2W-1:0]              prod2_d, prod2_q;
  logic [mahd_pkg::DivXW-1:0]  rem;

  always_comb begin
    unique case (fs_i)
      mahd_pkg::Fs44k1: begin
        recip = mahd_pkg::Recip44k1;
        dsr   = mahd_pkg::Div44k1;
      end
      mahd_pkg::Fs48k: begin
        recip = mahd_pkg::Recip48k;
        dsr   = mahd_pkg::Div48k;
      end
      default: begin
        recip = mahd_pkg::Recip32k;
        dsr   = mahd_pkg::Div32k;
      end
    endcase
  end

  // estimate is exact or one short
  assign prod_d  = x_i * recip;
  assign qest    = prod_q[PW-1:mahd_pkg::DivShift];
  assign prod2_d = qest * da_q;
  assign rem     = xb_q - prod2_q[mahd_pkg::DivXW-1:0];
  assign q_d     = qb_q + mahd_pkg::DivQW'(rem >= mahd_pkg::DivXW'(db_q));

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= prod_d;
      xa_q   <= x_i;
      da_q   <= dsr;
    end
    if (en_i[1]) begin
      prod2_q <= prod2_d;
      qb_q    <= qest;
      xb_q    <= xa_q;
      db_q    <= da_q;
    end
    if (en_i[2]) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

`default_nettype wire

@@ test/tb_mpeg_audio_header_decoder.sv @@
// testbench for mpeg_audio_header_decoder: a directed table of header words, then random
// headers, checked field by field against a behavioural decoder held in the bench
// depends on mahd_pkg (status and samplerate codes) and the rtl of the decoder
`timescale 1ns / 1ps

module tb_mpeg_audio_header_decoder;

  localparam int unsigned RandomRequests = 500;
  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned DrainCycles    = 12;
  localparam int unsigned IdlePercent    = 13;
  localparam int unsigned CalmFirst      = 150;
  localparam int unsigned CalmLast       = 249;

  localparam logic [1:0] VerMpeg25     = 2'b00;
  localparam logic [1:0] VerReserved   = 2'b01;
  localparam logic [1:0] VerMpeg2      = 2'b10;
  localparam logic [1:0] VerMpeg1      = 2'b11;
  localparam logic [1:0] LayerReserved = 2'b00;
  localparam logic [1:0] ModeMono      = 2'b11;
  localparam logic [3:0] BitrateBad    = 4'd15;
  localparam logic [1:0] FsBad         = 2'd3;
  localparam logic [10:0] SyncWord     = 11'h7ff;

  typedef struct packed {
    mahd_pkg::status_e status;
    logic [2:0]        layer;
    logic [18:0]       bitrate_bps;
    logic [15:0]       samplerate_hz;
    logic [11:0]       frame_bytes;
    logic [1:0]        channels;
    logic [10:0]       pcm_samples;
    logic [17:0]       frame_time_us;
    logic              padding;
    logic              free_format;
    logic              crc_follows;
    logic [15:0]       header_crc;
  } hdr_fields_t;

  // pinned rows carry a typed-in status and frame length
  typedef struct packed {
    logic [31:0]       word;
    logic              pinned;
    mahd_pkg::status_e status;
    logic [11:0]       frame_bytes;
  } stim_row_t;

  localparam int unsigned NumDirected = 22;
  localparam stim_row_t DirectedRows [NumDirected] = '{
    '{32'h00000000, 1'b1, mahd_pkg::StNoSync,     12'd0},
    '{32'hffc00000, 1'b1, mahd_pkg::StNoSync,     12'd0},
    '{32'hffe00000, 1'b1, mahd_pkg::StBadLayer,   12'd0},
    '{32'hffeb9000, 1'b1, mahd_pkg::StLostSync,   12'd0},
    '{32'hffe99000, 1'b1, mahd_pkg::StLostSync,   12'd0},
    '{32'hfff99000, 1'b1, mahd_pkg::StBadLayer,   12'd0},
    '{32'hfffbf000, 1'b1, mahd_pkg::StBadBitrate, 12'd0},
    '{32'hfffbfc00, 1'b1, mahd_pkg::StBadBitrate, 12'd0},
    '{32'hfffb9c00, 1'b1, mahd_pkg::StBadRate,    12'd0},
    '{32'hffffffff, 1'b1, mahd_pkg::StBadBitrate, 12'd0},
    '{32'hfffe0cff, 1'b1, mahd_pkg::StBadRate,    12'd0},
    '{32'hfffb0000, 1'b1, mahd_pkg::StOk,         12'd0},
    '{32'hfffb9064, 1'b1, mahd_pkg::StOk,         12'd417},
    '{32'hffffeac0, 1'b1, mahd_pkg::StOk,         12'd676},
    '{32'hffe5ea00, 1'b1, mahd_pkg::StOk,         12'd2881},
    '{32'hfffa9064, 1'b0, mahd_pkg::StOk,         12'd0},
    '{32'hfff39064, 1'b0, mahd_pkg::StOk,         12'd0},
    '{32'hfff59264, 1'b0, mahd_pkg::StOk,         12'd0},
    '{32'hfff7a0c0, 1'b0, mahd_pkg::StOk,         12'd0},
    '{32'hffe7e400, 1'b0, mahd_pkg::StOk,         12'd0},
    '{32'hffe31000, 1'b0, mahd_pkg::StOk,         12'd0},
    '{32'hfffd1800, 1'b0, mahd_pkg::StOk,         12'd0}
  };

  // kbit/s by row: v1 l1, v1 l2, v1 l3, lsf l1, lsf l2/l3
  localparam int unsigned KbpsByRow [5][15] = '{
    '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384},
    '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256},
    '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] header_word_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  status_o;
  logic [2:0]  layer_o;
  logic [18:0] bitrate_bps_o;
  logic [15:0] samplerate_hz_o;
  logic [11:0] frame_bytes_o;
  logic [1:0]  channels_o;
  logic [10:0] pcm_samples_o;
  logic [17:0] frame_time_us_o;
  logic        padding_o;
  logic        free_format_o;
  logic        crc_follows_o;
  logic [15:0] header_crc_o;

  hdr_fields_t pending_headers [$];
  int unsigned mismatches;
  int unsigned results_seen;
  bit          calm;

  mpeg_audio_header_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .header_word_i  (header_word_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .layer_o        (layer_o),
    .bitrate_bps_o  (bitrate_bps_o),
    .samplerate_hz_o(samplerate_hz_o),
    .frame_bytes_o  (frame_bytes_o),
    .channels_o     (channels_o),
    .pcm_samples_o  (pcm_samples_o),
    .frame_time_us_o(frame_time_us_o),
    .padding_o      (padding_o),
    .free_format_o  (free_format_o),
    .crc_follows_o  (crc_follows_o),
    .header_crc_o   (header_crc_o)
  );

  function automatic logic [15:0] crc16_low_half(input logic [15:0] data);
    logic [15:0] crc;
    logic        fb;
    crc = 16'hffff;
    for (int i = 15; i >= 0; i--) begin
      fb  = data[i] ^ crc[15];
      crc = {crc[14:0], 1'b0};
      if (fb) begin
        crc = crc ^ 16'h8005;
      end
    end
    return crc;
  endfunction

  function automatic hdr_fields_t decode_header(input logic [31:0] w);
    hdr_fields_t r;
    logic        v25;
    logic        lsf;
    logic [3:0]  bidx;
    logic [1:0]  fidx;
    int unsigned lay;
    int unsigned row;
    int unsigned br;
    int unsigned sr;
    int unsigned pcm;
    r = '0;
    r.status = mahd_pkg::StNoSync;
    if (w[31:21] != SyncWord) begin
      return r;
    end
    v25  = (w[20] == 1'b0);
    lsf  = (w[19] == 1'b0);
    lay  = 4 - w[18:17];
    bidx = w[15:12];
    fidx = w[11:10];
    pcm  = (lay == 1) ? 384 : ((lay == 3 && lsf) ? 576 : 1152);
    r.layer         = 3'(lay);
    r.padding       = w[9];
    r.channels      = (w[7:6] == ModeMono) ? 2'd1 : 2'd2;
    r.pcm_samples   = 11'(pcm);
    r.crc_follows   = !w[16];
    r.header_crc    = crc16_low_half(w[15:0]);
    if (w[20:19] == VerReserved) begin
      r.status = mahd_pkg::StLostSync;
    end else if (w[18:17] == LayerReserved) begin
      r.status = mahd_pkg::StBadLayer;
    end else if (bidx == BitrateBad) begin
      r.status = mahd_pkg::StBadBitrate;
    end else if (fidx == FsBad) begin
      r.status = mahd_pkg::StBadRate;
    end else begin
      r.status = mahd_pkg::StOk;
      row = lsf ? (3 + (lay >> 1)) : (lay - 1);
      br  = KbpsByRow[row][bidx] * 1000;
      case (mahd_pkg::fs_e'(fidx))
        mahd_pkg::Fs44k1: sr = 44100;
        mahd_pkg::Fs48k:  sr = 48000;
        default:          sr = 32000;
      endcase
      if (lsf) begin
        sr = v25 ? sr / 4 : sr / 2;
      end
      r.bitrate_bps   = 19'(br);
      r.samplerate_hz = 16'(sr);
      r.frame_time_us = 18'((longint'(pcm) * 1000000) / sr);
      if (bidx == 4'd0) begin
        r.free_format = 1'b1;
      end else if (lay == 1) begin
        r.frame_bytes = 12'((12 * br / sr + w[9]) * 4);
      end else if (lay == 3 && lsf) begin
        r.frame_bytes = 12'(72 * br / sr + w[9]);
      end else begin
        r.frame_bytes = 12'(144 * br / sr + w[9]);
      end
    end
    return r;
  endfunction

  // mostly well-formed headers with random content, the rest noise or one field broken
  function automatic logic [31:0] random_header();
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(99) < 20 && $urandom_range(4) == 0) begin
      return w;
    end
    w[31:21] = SyncWord;
    case ($urandom_range(2))
      0:       w[20:19] = VerMpeg25;
      1:       w[20:19] = VerMpeg2;
      default: w[20:19] = VerMpeg1;
    endcase
    w[18:17] = 2'($urandom_range(1, 3));
    w[15:12] = 4'($urandom_range(0, 14));
    w[11:10] = 2'($urandom_range(0, 2));
    if ($urandom_range(99) < 16) begin
      case ($urandom_range(3))
        0:       w[20:19] = VerReserved;
        1:       w[18:17] = LayerReserved;
        2:       w[15:12] = BitrateBad;
        default: w[11:10] = FsBad;
      endcase
    end
    return w;
  endfunction

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < IdlePercent);
  endfunction

  function automatic hdr_fields_t observed_result();
    hdr_fields_t r;
    r.status        = mahd_pkg::status_e'(status_o);
    r.layer         = layer_o;
    r.bitrate_bps   = bitrate_bps_o;
    r.samplerate_hz = samplerate_hz_o;
    r.frame_bytes   = frame_bytes_o;
    r.channels      = channels_o;
    r.pcm_samples   = pcm_samples_o;
    r.frame_time_us = frame_time_us_o;
    r.padding       = padding_o;
    r.free_format   = free_format_o;
    r.crc_follows   = crc_follows_o;
    r.header_crc    = header_crc_o;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic compare_fields(input hdr_fields_t got, input hdr_fields_t want);
    if (got.status !== want.status) begin
      report_mismatch("status", 32'(got.status), 32'(want.status));
    end
    if (got.layer !== want.layer) begin
      report_mismatch("layer", 32'(got.layer), 32'(want.layer));
    end
    if (got.bitrate_bps !== want.bitrate_bps) begin
      report_mismatch("bitrate_bps", 32'(got.bitrate_bps), 32'(want.bitrate_bps));
    end
    if (got.samplerate_hz !== want.samplerate_hz) begin
      report_mismatch("samplerate_hz", 32'(got.samplerate_hz), 32'(want.samplerate_hz));
    end
    if (got.frame_bytes !== want.frame_bytes) begin
      report_mismatch("frame_bytes", 32'(got.frame_bytes), 32'(want.frame_bytes));
    end
    if (got.channels !== want.channels) begin
      report_mismatch("channels", 32'(got.channels), 32'(want.channels));
    end
    if (got.pcm_samples !== want.pcm_samples) begin
      report_mismatch("pcm_samples", 32'(got.pcm_samples), 32'(want.pcm_samples));
    end
    if (got.frame_time_us !== want.frame_time_us) begin
      report_mismatch("frame_time_us", 32'(got.frame_time_us), 32'(want.frame_time_us));
    end
    if (got.padding !== want.padding) begin
      report_mismatch("padding", 32'(got.padding), 32'(want.padding));
    end
    if (got.free_format !== want.free_format) begin
      report_mismatch("free_format", 32'(got.free_format), 32'(want.free_format));
    end
    if (got.crc_follows !== want.crc_follows) begin
      report_mismatch("crc_follows", 32'(got.crc_follows), 32'(want.crc_follows));
    end
    if (got.header_crc !== want.header_crc) begin
      report_mismatch("header_crc", 32'(got.header_crc), 32'(want.header_crc));
    end
  endtask

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic send_header(input logic [31:0] w, input hdr_fields_t want);
    while (take_break()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    header_word_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_headers.push_back(want);
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ready_i <= !take_break();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_headers.size() == 0) begin
        report_mismatch("result with no request pending", 32'(status_o), 32'd0);
      end else begin
        compare_fields(observed_result(), pending_headers.pop_front());
      end
      results_seen++;
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    hdr_fields_t want;
    logic [31:0] w;
    mismatches    = 0;
    results_seen  = 0;
    calm          = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    header_word_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DirectedRows[i]) begin
      want = decode_header(DirectedRows[i].word);
      if (DirectedRows[i].pinned) begin
        want.status      = DirectedRows[i].status;
        want.frame_bytes = DirectedRows[i].frame_bytes;
      end
      send_header(DirectedRows[i].word, want);
    end

    for (int n = 0; n < RandomRequests; n++) begin
      calm = (n >= CalmFirst && n <= CalmLast);
      w = random_header();
      send_header(w, decode_header(w));
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (pending_headers.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ mpeg_audio_header_decoder.f @@
design/mahd_pkg.sv
design/mahd_cdiv.sv
design/mpeg_audio_header_decoder.sv
test/tb_mpeg_audio_header_decoder.sv
